[rtl/mwq_pkg.sv]
package mwq_pkg;

  localparam int NUM_LOCKS  = 3;
  localparam int WAIT_DEPTH = 16;

  localparam int LOCK_W   = 2;
  localparam int PID_W    = 8;
  localparam int STATUS_W = 3;
  localparam int IDX_W    = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;
  localparam int PTR_W    = $clog2(WAIT_DEPTH);
  localparam int CNT_W    = $clog2(WAIT_DEPTH + 1);
  localparam int ADDR_W   = $clog2(NUM_LOCKS * WAIT_DEPTH);

  localparam int S_DATA_W = 16;
  localparam int M_DATA_W = 24;

  localparam logic [STATUS_W-1:0] ST_GRANTED   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BLOCKED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RELEASED  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_HANDED    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NOT_OWNER = 3'd5;
  localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd6;

  localparam logic ACT_WAIT   = 1'b0;
  localparam logic ACT_SIGNAL = 1'b1;

  typedef struct packed {
    logic load;
    logic exec;
    logic finish;
  } mwq_cmd_t;

  typedef struct packed {
    logic handover;
  } mwq_stat_t;

endpackage

[rtl/mwq_ram.sv]
module mwq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/mwq_ctrl.sv]
module mwq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output mwq_pkg::mwq_cmd_t  cmd,
  input  mwq_pkg::mwq_stat_t stat
);

  import mwq_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_FETCH = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_valid;
  logic       out_set;
  logic       out_free;

  assign out_free      = !out_valid || m_axis_tready;
  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = out_valid;

  always_comb begin
    state_next = state;
    cmd        = '0;
    out_set    = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        // wait for the result register to drain before touching lock state
        if (out_free) begin
          cmd.exec = 1'b1;
          if (stat.handover) begin
            state_next = S_FETCH;
          end else begin
            out_set    = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      S_FETCH: begin
        cmd.finish = 1'b1;
        out_set    = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_set) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[rtl/mwq_dp.sv]
module mwq_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         action,
  input  logic [mwq_pkg::LOCK_W-1:0]   lock_id,
  input  logic [mwq_pkg::PID_W-1:0]    requester_pid,
  input  mwq_pkg::mwq_cmd_t            cmd,
  output mwq_pkg::mwq_stat_t           stat,
  output logic [mwq_pkg::STATUS_W-1:0] status,
  output logic [mwq_pkg::PID_W-1:0]    woken_pid,
  output logic [mwq_pkg::PID_W-1:0]    owner_after
);

  import mwq_pkg::*;

  logic              req_action;
  logic [LOCK_W-1:0] req_lk;
  logic [PID_W-1:0]  req_pid;

  logic              lock_held  [NUM_LOCKS];
  logic [PID_W-1:0]  lock_owner [NUM_LOCKS];
  logic [PTR_W-1:0]  queue_head [NUM_LOCKS];
  logic [PTR_W-1:0]  queue_tail [NUM_LOCKS];
  logic [CNT_W-1:0]  queue_count[NUM_LOCKS];

  logic                lk_ok;
  logic [IDX_W-1:0]    idx;
  logic                held;
  logic [PID_W-1:0]    owner;
  logic [PTR_W-1:0]    head;
  logic [PTR_W-1:0]    tail;
  logic [CNT_W-1:0]    cnt;
  logic [STATUS_W-1:0] decision;
  logic [PID_W-1:0]    owner_new;
  logic [ADDR_W-1:0]   base;
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [PID_W-1:0]    ram_rdata;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    ring_next = (p == PTR_W'(WAIT_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign lk_ok = ({1'b0, req_lk} < (LOCK_W + 1)'(NUM_LOCKS));
  assign idx   = lk_ok ? req_lk[IDX_W-1:0] : '0;
  assign held  = lock_held[idx];
  assign owner = lock_owner[idx];
  assign head  = queue_head[idx];
  assign tail  = queue_tail[idx];
  assign cnt   = queue_count[idx];
  assign base  = ADDR_W'(idx) * ADDR_W'(WAIT_DEPTH);

  always_comb begin
    decision  = ST_INVALID;
    owner_new = '0;
    if (lk_ok) begin
      owner_new = held ? owner : '0;
      if (req_action == ACT_WAIT) begin
        if (!held) begin
          decision  = ST_GRANTED;
          owner_new = req_pid;
        end else if (cnt == CNT_W'(WAIT_DEPTH)) begin
          decision = ST_FULL;
        end else begin
          decision = ST_BLOCKED;
        end
      end else begin
        if (!held || owner != req_pid) begin
          decision = ST_NOT_OWNER;
        end else if (cnt == '0) begin
          decision  = ST_RELEASED;
          owner_new = '0;
        end else begin
          decision = ST_HANDED;
        end
      end
    end
  end

  assign stat.handover = (decision == ST_HANDED);

  assign ram_we    = cmd.exec && (decision == ST_BLOCKED);
  assign ram_waddr = base + ADDR_W'(tail);
  assign ram_raddr = base + ADDR_W'(head);

  mwq_ram #(
    .WIDTH (PID_W),
    .DEPTH (NUM_LOCKS * WAIT_DEPTH)
  ) u_waiters (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (req_pid),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_action <= action;
      req_lk     <= lock_id;
      req_pid    <= requester_pid;
    end
    if (cmd.exec && decision != ST_HANDED) begin
      status      <= decision;
      woken_pid   <= '0;
      owner_after <= owner_new;
    end
    if (cmd.finish) begin
      status      <= ST_HANDED;
      woken_pid   <= ram_rdata;
      owner_after <= ram_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_LOCKS; i++) begin
        lock_held[i]   <= 1'b0;
        lock_owner[i]  <= '0;
        queue_head[i]  <= '0;
        queue_tail[i]  <= '0;
        queue_count[i] <= '0;
      end
    end else begin
      if (cmd.exec) begin
        case (decision)
          ST_GRANTED: begin
            lock_held[idx]  <= 1'b1;
            lock_owner[idx] <= req_pid;
          end
          ST_BLOCKED: begin
            queue_tail[idx]  <= ring_next(tail);
            queue_count[idx] <= cnt + 1'b1;
          end
          ST_RELEASED: begin
            lock_held[idx]  <= 1'b0;
            lock_owner[idx] <= '0;
          end
          ST_HANDED: begin
            queue_head[idx]  <= ring_next(head);
            queue_count[idx] <= cnt - 1'b1;
          end
          default: begin
          end
        endcase
      end
      // new owner arrives from the registered waiter memory read in the cycle after it
      if (cmd.finish) begin
        lock_owner[idx] <= ram_rdata;
      end
    end
  end

endmodule

[rtl/mutex_with_fifo_wait_queue_core.sv]
// Each beat is accepted, then executed once the result register is free; a hand-over
// adds a fetch step for the registered waiter memory read before the result is set.
// The controller takes one request at a time through accept, execute and fetch
// steps, and it accepts no new beat until the current one is done.
// Reset (rst, synchronous): all locks free, queues empty, no result pending.
module mutex_with_fifo_wait_queue_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [mwq_pkg::S_DATA_W-1:0] s_axis_tdata,  // lock_id[1:0], requester_pid[9:2]
  input  logic [0:0]                   s_axis_tuser,  // action[0]
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [mwq_pkg::M_DATA_W-1:0] m_axis_tdata   // status[2:0], woken_pid[10:3],
                                                      // owner_after[18:11]
);

  import mwq_pkg::*;

  mwq_cmd_t            cmd;
  mwq_stat_t           stat;
  logic [STATUS_W-1:0] status;
  logic [PID_W-1:0]    woken_pid;
  logic [PID_W-1:0]    owner_after;

  mwq_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cmd           (cmd),
    .stat          (stat)
  );

  mwq_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .action        (s_axis_tuser[0]),
    .lock_id       (s_axis_tdata[LOCK_W-1:0]),
    .requester_pid (s_axis_tdata[LOCK_W+PID_W-1:LOCK_W]),
    .cmd           (cmd),
    .stat          (stat),
    .status        (status),
    .woken_pid     (woken_pid),
    .owner_after   (owner_after)
  );

  assign m_axis_tdata = {5'b0, owner_after, woken_pid, status};

endmodule

[verif/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mwq_pkg::*;

  localparam int RANDOM_ITEMS = 1100;
  localparam int MAX_IDLE     = 17;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PID_W-1:0]    woken;
    logic [PID_W-1:0]    owner;
  } lock_reply_t;

  typedef struct {
    logic              act;
    logic [LOCK_W-1:0] lk;
    logic [PID_W-1:0]  pid;
    bit                typed;
    lock_reply_t       want;
  } request_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [S_DATA_W-1:0] s_axis_tdata = '0;
  logic [0:0]          s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0] m_axis_tdata;

  // Lock bank as the block should see it
  bit               held [NUM_LOCKS];
  logic [PID_W-1:0] owner [NUM_LOCKS];
  logic [PID_W-1:0] waiters [NUM_LOCKS][WAIT_DEPTH];
  int               wq_head [NUM_LOCKS];
  int               wq_fill [NUM_LOCKS];

  lock_reply_t replies_due[$];
  int          err_count = 0;
  int          sent = 0;
  int          rcvd = 0;
  int          rx_hold = 0;
  bit          tx_gaps_on = 1'b1;
  bit          rx_stalls_on = 1'b1;
  bit          paused_once = 1'b0;

  request_row_t steps [18] = '{
    '{ACT_WAIT,   2'd0, 8'd1,   1'b1, '{ST_GRANTED,   8'd0,   8'd1}},
    '{ACT_SIGNAL, 2'd0, 8'd2,   1'b1, '{ST_NOT_OWNER, 8'd0,   8'd1}},
    '{ACT_WAIT,   2'd0, 8'd255, 1'b1, '{ST_BLOCKED,   8'd0,   8'd1}},
    '{ACT_WAIT,   2'd0, 8'd1,   1'b0, '0},
    '{ACT_SIGNAL, 2'd0, 8'd1,   1'b1, '{ST_HANDED,    8'd255, 8'd255}},
    '{ACT_SIGNAL, 2'd0, 8'd255, 1'b0, '0},
    '{ACT_SIGNAL, 2'd0, 8'd1,   1'b1, '{ST_RELEASED,  8'd0,   8'd0}},
    '{ACT_SIGNAL, 2'd0, 8'd1,   1'b1, '{ST_NOT_OWNER, 8'd0,   8'd0}},
    '{ACT_WAIT,   2'd3, 8'd255, 1'b1, '{ST_INVALID,   8'd0,   8'd0}},
    '{ACT_SIGNAL, 2'd3, 8'd1,   1'b1, '{ST_INVALID,   8'd0,   8'd0}},
    '{ACT_WAIT,   2'd2, 8'd0,   1'b1, '{ST_GRANTED,   8'd0,   8'd0}},
    '{ACT_WAIT,   2'd2, 8'd7,   1'b0, '0},
    '{ACT_SIGNAL, 2'd2, 8'd0,   1'b0, '0},
    '{ACT_SIGNAL, 2'd2, 8'd7,   1'b0, '0},
    '{ACT_WAIT,   2'd1, 8'hAA,  1'b0, '0},
    '{ACT_WAIT,   2'd1, 8'h55,  1'b0, '0},
    '{ACT_SIGNAL, 2'd1, 8'hAA,  1'b0, '0},
    '{ACT_SIGNAL, 2'd1, 8'h55,  1'b0, '0}
  };

  mutex_with_fifo_wait_queue_core u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic lock_reply_t arbitrate(logic act, logic [LOCK_W-1:0] lk,
                                            logic [PID_W-1:0] pid);
    lock_reply_t r;
    r = '0;
    if (lk >= NUM_LOCKS) begin
      r.status = ST_INVALID;
      return r;
    end
    if (act == ACT_WAIT) begin
      if (!held[lk]) begin
        held[lk]  = 1'b1;
        owner[lk] = pid;
        r.status  = ST_GRANTED;
      end else if (wq_fill[lk] >= WAIT_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        waiters[lk][(wq_head[lk] + wq_fill[lk]) % WAIT_DEPTH] = pid;
        wq_fill[lk]++;
        r.status = ST_BLOCKED;
      end
    end else begin
      if (!held[lk] || owner[lk] != pid) begin
        r.status = ST_NOT_OWNER;
      end else if (wq_fill[lk] == 0) begin
        held[lk]  = 1'b0;
        owner[lk] = '0;
        r.status  = ST_RELEASED;
      end else begin
        // hand the lock to the oldest waiter
        r.woken     = waiters[lk][wq_head[lk]];
        wq_head[lk] = (wq_head[lk] + 1) % WAIT_DEPTH;
        wq_fill[lk]--;
        owner[lk]   = r.woken;
        r.status    = ST_HANDED;
      end
    end
    r.owner = held[lk] ? owner[lk] : '0;
    return r;
  endfunction

  task automatic push_request(logic act, logic [LOCK_W-1:0] lk, logic [PID_W-1:0] pid,
                              bit typed, lock_reply_t want);
    int gap;
    lock_reply_t model;
    gap = tx_gaps_on ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(S_DATA_W - PID_W - LOCK_W){1'b0}}, pid, lk};
    s_axis_tuser  <= act;
    do @(posedge clk); while (!s_axis_tready);
    model = arbitrate(act, lk, pid);
    replies_due.push_back(typed ? want : model);
    sent++;
    if (sent % 64 == 0) tx_gaps_on = ($urandom_range(0, 3) != 0);
  endtask

  task automatic drain_replies();
    s_axis_tvalid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
  endtask

  // Queue up a lock past full, then release it through every waiter
  task automatic fill_and_drain();
    int lk;
    int n;
    lk = $urandom_range(0, NUM_LOCKS - 1);
    n  = WAIT_DEPTH - wq_fill[lk] + $urandom_range(1, 3) + (held[lk] ? 0 : 1);
    repeat (n) push_request(ACT_WAIT, lk, $urandom_range(0, 255), 1'b0, '0);
    n = wq_fill[lk] + 1;
    repeat (n) push_request(ACT_SIGNAL, lk, owner[lk], 1'b0, '0);
  endtask

  task automatic random_request();
    int r;
    logic [LOCK_W-1:0] lk;
    logic [PID_W-1:0]  pid;
    r   = $urandom_range(0, 99);
    lk  = $urandom_range(0, NUM_LOCKS - 1);
    pid = $urandom_range(0, 255);
    if (r < 8 && NUM_LOCKS < (1 << LOCK_W)) begin
      lk = $urandom_range(NUM_LOCKS, (1 << LOCK_W) - 1);
      push_request(logic'($urandom_range(0, 1)), lk, pid, 1'b0, '0);
    end else if (r < 50) begin
      if (r < 14 && held[lk]) pid = owner[lk];
      push_request(ACT_WAIT, lk, pid, 1'b0, '0);
    end else if (r < 88) begin
      if (held[lk]) pid = owner[lk];
      push_request(ACT_SIGNAL, lk, pid, 1'b0, '0);
    end else begin
      push_request(ACT_SIGNAL, lk, pid, 1'b0, '0);
    end
  endtask

  task automatic flag_error(string what, lock_reply_t want, lock_reply_t got);
    err_count++;
    if (err_count <= 10)
      $display("%0t: %s: want status %0d woken %0d owner %0d, got status %0d woken %0d owner %0d",
               $realtime, what, want.status, want.woken, want.owner,
               got.status, got.woken, got.owner);
  endtask

  always @(posedge clk) begin
    int nxt;
    lock_reply_t got;
    lock_reply_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
      rx_hold = 0;
    end else begin
      nxt = rx_hold;
      if (m_axis_tvalid && m_axis_tready) begin
        got.status = m_axis_tdata[2:0];
        got.woken  = m_axis_tdata[10:3];
        got.owner  = m_axis_tdata[18:11];
        if (replies_due.size() == 0) begin
          flag_error("result with nothing pending", '0, got);
        end else begin
          want = replies_due.pop_front();
          if (got.status != want.status) flag_error("status mismatch", want, got);
          else if (got.woken != want.woken) flag_error("woken_pid mismatch", want, got);
          else if (got.owner != want.owner) flag_error("owner_after mismatch", want, got);
        end
        rcvd++;
        if (rcvd % 64 == 0) rx_stalls_on = ($urandom_range(0, 3) != 0);
        nxt = rx_stalls_on ? $urandom_range(0, MAX_IDLE) : 0;
      end else if (nxt > 0) begin
        nxt--;
      end
      rx_hold = nxt;
      m_axis_tready <= (nxt == 0);
    end
  end

  initial begin
    for (int i = 0; i < NUM_LOCKS; i++) begin
      held[i]    = 1'b0;
      owner[i]   = '0;
      wq_head[i] = 0;
      wq_fill[i] = 0;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (steps[i])
      push_request(steps[i].act, steps[i].lk, steps[i].pid, steps[i].typed, steps[i].want);
    drain_replies();

    while (sent < $size(steps) + RANDOM_ITEMS) begin
      if ($urandom_range(0, 99) < 6) fill_and_drain();
      else random_request();
      // hold off once mid-run until the pipeline is empty
      if (!paused_once && sent >= $size(steps) + RANDOM_ITEMS / 2) begin
        paused_once = 1'b1;
        drain_replies();
      end
    end

    drain_replies();
    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("mutex_with_fifo_wait_queue_core regression: pass");
    end else begin
      $display("mutex_with_fifo_wait_queue_core regression: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("mutex_with_fifo_wait_queue_core regression: fail");
    $finish;
  end

endmodule
